// ----- sv/dda_ray_setup_unit_defines.svh -----
// Assertion macros shared by the ray setup RTL.
`ifndef DDA_RAY_SETUP_UNIT_DEFINES_SVH
`define DDA_RAY_SETUP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/drs_pkg.sv -----
// Types and constants of the DDA ray setup unit.
`timescale 1ns / 1ps

package drs_pkg;

   localparam int COLUMN_W   = 12;
   localparam int DIR_W      = 18;
   localparam int MAG_W      = 17;
   localparam int CELL_W     = 8;
   localparam int DIST_W     = 32;
   localparam int POS_W      = 24;
   localparam int FRAC_W     = 16;
   localparam int SCALE_W    = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [MAG_W-1:0]  ONE_Q16   = 17'h10000;
   localparam logic [DIST_W-1:0] DIST_ONE  = 32'h0001_0000;
   localparam logic [DIST_W-1:0] DIST_MAX  = 32'hFFFF_FFFF;

   // Register indexes, paddr[3:2]
   localparam logic [1:0] REG_ORIENTATION = 2'd0;
   localparam logic [1:0] REG_POS_X       = 2'd1;
   localparam logic [1:0] REG_POS_Y       = 2'd2;
   localparam logic [1:0] REG_PLANE_SCALE = 2'd3;

   localparam logic [POS_W-1:0]   POS_RESET   = 24'd98304;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd43254;

   typedef enum logic [1:0] {
      ORIENT_NORTH = 2'd0,
      ORIENT_SOUTH = 2'd1,
      ORIENT_EAST  = 2'd2,
      ORIENT_WEST  = 2'd3
   } orient_type;

   // Per-ray context carried alongside the reciprocal pipeline
   typedef struct packed {
      logic [FRAC_W-1:0] pmag;      // plane component magnitude (divisor)
      logic              pneg;      // plane component negative
      logic              axis_neg;  // facing axis negative
      logic              p_on_x;    // plane component lies on x
   } tag_type;

endpackage

// ----- sv/drs_if.sv -----
// Request and response channel interfaces of the ray setup unit.
`timescale 1ns / 1ps

interface drs_req_if;
   logic                          valid;
   logic                          ready;
   logic [drs_pkg::COLUMN_W-1:0]  column;

   modport source (output valid, output column, input ready);
   modport sink   (input valid, input column, output ready);
endinterface

interface drs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [drs_pkg::DIR_W-1:0]  ray_dir_x;
   logic signed [drs_pkg::DIR_W-1:0]  ray_dir_y;
   logic [drs_pkg::CELL_W-1:0]        cell_x;
   logic [drs_pkg::CELL_W-1:0]        cell_y;
   logic                              step_neg_x;
   logic                              step_neg_y;
   logic [drs_pkg::DIST_W-1:0]        delta_x;
   logic [drs_pkg::DIST_W-1:0]        delta_y;
   logic [drs_pkg::DIST_W-1:0]        side_x;
   logic [drs_pkg::DIST_W-1:0]        side_y;

   modport source (output valid, output ray_dir_x, output ray_dir_y, output cell_x,
                   output cell_y, output step_neg_x, output step_neg_y, output delta_x,
                   output delta_y, output side_x, output side_y, input ready);
   modport sink   (input valid, input ray_dir_x, input ray_dir_y, input cell_x,
                   input cell_y, input step_neg_x, input step_neg_y, input delta_x,
                   input delta_y, input side_x, input side_y, output ready);
endinterface

// ----- sv/drs_recip.sv -----
// Pipelined reciprocal 2^32 / pmag, four quotient bits per stage, saturating.
`timescale 1ns / 1ps

module drs_recip (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  drs_pkg::tag_type              in_tag,
   output logic                          out_valid,
   input  logic                          out_ready,
   output drs_pkg::tag_type              out_tag,
   output logic [drs_pkg::DIST_W-1:0]    out_quot
);

   localparam int STEPS = drs_pkg::DIST_W;
   localparam int PER   = 4;
   localparam int NST   = STEPS / PER;
   localparam int RW    = drs_pkg::FRAC_W;

   logic [NST-1:0]          v_ff;
   logic [NST-1:0]          v_in;
   logic [NST-1:0]          en;
   logic [RW-1:0]           rem_ff [NST];
   logic [RW-1:0]           rem_in [NST];
   logic [STEPS-1:0]        quo_ff [NST];
   logic [STEPS-1:0]        quo_in [NST];
   drs_pkg::tag_type        tag_ff [NST];
   drs_pkg::tag_type        tag_in [NST];

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || out_ready;
      for (int s = NST - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   // Restoring division; the leading dividend bit is pre-loaded as remainder 1,
   // valid for any divisor of two or more.
   always_comb begin
      logic [RW-1:0]    r;
      logic [STEPS-1:0] q;
      logic [RW:0]      r2;
      drs_pkg::tag_type t;
      for (int s = 0; s < NST; s++) begin
         if (s == 0) begin
            r    = RW'(1);
            q    = '0;
            t    = in_tag;
            v_in[s] = en[s] ? in_valid : v_ff[s];
         end else begin
            r    = rem_ff[s-1];
            q    = quo_ff[s-1];
            t    = tag_ff[s-1];
            v_in[s] = en[s] ? v_ff[s-1] : v_ff[s];
         end
         for (int k = 0; k < PER; k++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, t.pmag}) begin
               r = RW'(r2 - {1'b0, t.pmag});
               q = {q[STEPS-2:0], 1'b1};
            end else begin
               r = r2[RW-1:0];
               q = {q[STEPS-2:0], 1'b0};
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
         tag_in[s] = t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NST; s++) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            tag_ff[s] <= tag_in[s];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NST-1];
   assign out_tag   = tag_ff[NST-1];
   // zero or one LSB does not fit: saturate
   assign out_quot  = (tag_ff[NST-1].pmag[RW-1:1] == '0) ? drs_pkg::DIST_MAX
                                                          : quo_ff[NST-1];

endmodule

// ----- sv/dda_ray_setup_unit.sv -----
// DDA ray setup unit: per-column ray direction, cell, delta and side distances.
//
// Usage: one screen column index enters per transaction on req_bus; one ray
// setup leaves per transaction on rsp_bus (valid/ready on both sides). The
// viewer orientation, position and plane scale are set through the APB port
// (orientation at 0x0, pos_x at 0x4, pos_y at 0x8, plane_scale at 0xC) and are
// read live by the pipeline, so they must be written by the user only while no ray is in
// flight; the block itself does not enforce this. From request accept to
// response valid a ray passes six front stages (column scaling by reciprocal
// multiply, camera coordinate, plane multiply, orientation select), eight
// stages of the reciprocal divider at four quotient bits each, then the
// side-distance multiply and the saturating output register.
// Throughput: one column per cycle unless stalled; every stage holds a
// valid bit and loads whenever the stage after it is empty or moving.
// Reset: clears all valid bits and restores the register defaults (north,
// position 1.5/1.5, plane 0.66). A stalled response holds its stage; bubbles
// upstream still fill, so requests keep being taken until the pipe is full.
`timescale 1ns / 1ps
`include "dda_ray_setup_unit_defines.svh"

module dda_ray_setup_unit #(
   parameter int SCREEN_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   drs_req_if.sink                           req_bus,
   drs_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [drs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [drs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [drs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int CW      = drs_pkg::COLUMN_W;
   localparam int MW      = drs_pkg::MAG_W;
   localparam int FW      = drs_pkg::FRAC_W;
   localparam int DW      = drs_pkg::DIST_W;
   localparam int RSH     = 12;                     // reciprocal precision bits
   localparam int RECIP   = (2 ** (MW + RSH)) / SCREEN_WIDTH;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = CW + RECIP_W;
   localparam int QW_W    = MW + 13;
   localparam int PP_W    = drs_pkg::SCALE_W + MW;
   localparam int SP_W    = MW + DW;

   // ---------------- configuration registers ----------------
   drs_pkg::orient_type                orient_ff;
   logic [drs_pkg::POS_W-1:0]          pos_x_ff;
   logic [drs_pkg::POS_W-1:0]          pos_y_ff;
   logic [drs_pkg::SCALE_W-1:0]        scale_ff;
   logic                               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= drs_pkg::ORIENT_NORTH;
         pos_x_ff  <= drs_pkg::POS_RESET;
         pos_y_ff  <= drs_pkg::POS_RESET;
         scale_ff  <= drs_pkg::SCALE_RESET;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            drs_pkg::REG_ORIENTATION: orient_ff <= drs_pkg::orient_type'(pwdata[1:0]);
            drs_pkg::REG_POS_X:       pos_x_ff  <= pwdata[drs_pkg::POS_W-1:0];
            drs_pkg::REG_POS_Y:       pos_y_ff  <= pwdata[drs_pkg::POS_W-1:0];
            drs_pkg::REG_PLANE_SCALE: scale_ff  <= pwdata[drs_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         drs_pkg::REG_ORIENTATION: prdata = 32'(orient_ff);
         drs_pkg::REG_POS_X:       prdata = 32'(pos_x_ff);
         drs_pkg::REG_POS_Y:       prdata = 32'(pos_y_ff);
         drs_pkg::REG_PLANE_SCALE: prdata = 32'(scale_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, vm_ff, vo_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in, v6_in, vm_in, vo_in;
   logic en1, en2, en3, en4, en5, en6, enm, eno;
   logic div_in_ready, div_out_valid;
   drs_pkg::tag_type div_out_tag;
   logic [DW-1:0]    div_quot;

   assign eno = !vo_ff || rsp_bus.ready;
   assign enm = !vm_ff || eno;
   assign en6 = !v6_ff || div_in_ready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;

   assign v1_in = en1 ? req_bus.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;
   assign v5_in = en5 ? v4_ff : v5_ff;
   assign v6_in = en6 ? v5_ff : v6_ff;
   assign vm_in = enm ? div_out_valid : vm_ff;
   assign vo_in = eno ? vm_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         vm_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
         vm_ff <= vm_in;
         vo_ff <= vo_in;
      end
   end

   // ---------------- front stages ----------------
   logic [CW-1:0]      col1_ff, col1_in, col2_ff;
   logic [PROD_W-1:0]  prod1_ff, prod1_in;
   logic [MW-1:0]      q2_ff, q2_in;
   logic [QW_W-1:0]    qw2_ff, qw2_in;
   logic [QW_W-1:0]    rem_c;
   logic [MW-1:0]      scaled3_ff, scaled3_in;
   logic               camneg4_ff, camneg4_in;
   logic [MW-1:0]      cammag4_ff, cammag4_in;
   logic               camneg5_ff;
   logic [PP_W-1:0]    pprod5_ff, pprod5_in;
   drs_pkg::tag_type   tag6_ff, tag6_in;
   logic [FW-1:0]      pmag6;

   // stage 1: clamp and multiply by the scaled reciprocal of the width
   assign col1_in  = (req_bus.column > CW'(SCREEN_WIDTH - 1)) ? CW'(SCREEN_WIDTH - 1)
                                                              : req_bus.column;
   assign prod1_in = PROD_W'(col1_in) * PROD_W'(RECIP);

   // stage 2: estimate is exact or one low
   assign q2_in  = MW'(prod1_ff >> RSH);
   assign qw2_in = QW_W'(q2_in) * QW_W'(SCREEN_WIDTH);

   // stage 3: one correction step
   assign rem_c      = (QW_W'(col2_ff) << MW) - qw2_ff;
   assign scaled3_in = (rem_c >= QW_W'(SCREEN_WIDTH)) ? MW'(q2_ff + 1'b1) : q2_ff;

   // stage 4: camera coordinate as sign and magnitude
   assign camneg4_in = (scaled3_ff < drs_pkg::ONE_Q16);
   assign cammag4_in = camneg4_in ? MW'(drs_pkg::ONE_Q16 - scaled3_ff)
                                  : MW'(scaled3_ff - drs_pkg::ONE_Q16);

   // stage 5: plane component
   assign pprod5_in = PP_W'(scale_ff) * PP_W'(cammag4_ff);

   // stage 6: place components by orientation
   assign pmag6 = pprod5_ff[FW +: FW];

   always_comb begin
      tag6_in.pmag = pmag6;
      unique case (orient_ff)
         drs_pkg::ORIENT_NORTH: begin
            tag6_in.p_on_x   = 1'b1;
            tag6_in.pneg     = camneg5_ff;
            tag6_in.axis_neg = 1'b1;
         end
         drs_pkg::ORIENT_SOUTH: begin
            tag6_in.p_on_x   = 1'b1;
            tag6_in.pneg     = !camneg5_ff;
            tag6_in.axis_neg = 1'b0;
         end
         drs_pkg::ORIENT_EAST: begin
            tag6_in.p_on_x   = 1'b0;
            tag6_in.pneg     = camneg5_ff;
            tag6_in.axis_neg = 1'b0;
         end
         default: begin
            tag6_in.p_on_x   = 1'b0;
            tag6_in.pneg     = !camneg5_ff;
            tag6_in.axis_neg = 1'b1;
         end
      endcase
      // a zero component steps in the positive direction
      if (pmag6 == '0) begin
         tag6_in.pneg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         col1_ff  <= col1_in;
         prod1_ff <= prod1_in;
      end
      if (en2) begin
         col2_ff <= col1_ff;
         q2_ff   <= q2_in;
         qw2_ff  <= qw2_in;
      end
      if (en3) begin
         scaled3_ff <= scaled3_in;
      end
      if (en4) begin
         camneg4_ff <= camneg4_in;
         cammag4_ff <= cammag4_in;
      end
      if (en5) begin
         camneg5_ff <= camneg4_ff;
         pprod5_ff  <= pprod5_in;
      end
      if (en6) begin
         tag6_ff <= tag6_in;
      end
   end

   // ---------------- reciprocal ----------------
   drs_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_ready  (div_in_ready),
      .in_tag    (tag6_ff),
      .out_valid (div_out_valid),
      .out_ready (enm),
      .out_tag   (div_out_tag),
      .out_quot  (div_quot)
   );

   // ---------------- side distance multiply ----------------
   logic                          negx_in, negy_in, negx_ff, negy_ff;
   logic [MW-1:0]                 magx, magy, fx, fy;
   logic [DW-1:0]                 dx_in, dy_in, dx_ff, dy_ff;
   logic signed [drs_pkg::DIR_W-1:0] dirx_in, diry_in, dirx_ff, diry_ff;
   logic [SP_W-1:0]               spx_in, spy_in, spx_ff, spy_ff;

   always_comb begin
      if (div_out_tag.p_on_x) begin
         magx    = MW'(div_out_tag.pmag);
         negx_in = div_out_tag.pneg;
         dx_in   = div_quot;
         magy    = drs_pkg::ONE_Q16;
         negy_in = div_out_tag.axis_neg;
         dy_in   = drs_pkg::DIST_ONE;
      end else begin
         magx    = drs_pkg::ONE_Q16;
         negx_in = div_out_tag.axis_neg;
         dx_in   = drs_pkg::DIST_ONE;
         magy    = MW'(div_out_tag.pmag);
         negy_in = div_out_tag.pneg;
         dy_in   = div_quot;
      end
      dirx_in = negx_in ? $signed(drs_pkg::DIR_W'(0) - drs_pkg::DIR_W'(magx))
                        : $signed(drs_pkg::DIR_W'(magx));
      diry_in = negy_in ? $signed(drs_pkg::DIR_W'(0) - drs_pkg::DIR_W'(magy))
                        : $signed(drs_pkg::DIR_W'(magy));
      // distance fraction to the first grid line in the stepping direction
      fx = negx_in ? MW'(pos_x_ff[FW-1:0]) : MW'(drs_pkg::ONE_Q16 - MW'(pos_x_ff[FW-1:0]));
      fy = negy_in ? MW'(pos_y_ff[FW-1:0]) : MW'(drs_pkg::ONE_Q16 - MW'(pos_y_ff[FW-1:0]));
      spx_in = SP_W'(fx) * SP_W'(dx_in);
      spy_in = SP_W'(fy) * SP_W'(dy_in);
   end

   always_ff @(posedge clock) begin
      if (enm) begin
         negx_ff <= negx_in;
         negy_ff <= negy_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dirx_ff <= dirx_in;
         diry_ff <= diry_in;
         spx_ff  <= spx_in;
         spy_ff  <= spy_in;
      end
   end

   // ---------------- output register ----------------
   logic [DW:0]                      sx, sy;
   logic [DW-1:0]                    side_x_ff, side_y_ff, delta_x_ff, delta_y_ff;
   logic signed [drs_pkg::DIR_W-1:0] rdx_ff, rdy_ff;
   logic                             stx_ff, sty_ff;

   assign sx = spx_ff[SP_W-1:FW];
   assign sy = spy_ff[SP_W-1:FW];

   always_ff @(posedge clock) begin
      if (eno) begin
         side_x_ff  <= sx[DW] ? drs_pkg::DIST_MAX : sx[DW-1:0];
         side_y_ff  <= sy[DW] ? drs_pkg::DIST_MAX : sy[DW-1:0];
         delta_x_ff <= dx_ff;
         delta_y_ff <= dy_ff;
         rdx_ff     <= dirx_ff;
         rdy_ff     <= diry_ff;
         stx_ff     <= negx_ff;
         sty_ff     <= negy_ff;
      end
   end

   assign rsp_bus.valid      = vo_ff;
   assign rsp_bus.ray_dir_x  = rdx_ff;
   assign rsp_bus.ray_dir_y  = rdy_ff;
   assign rsp_bus.cell_x     = pos_x_ff[drs_pkg::POS_W-1:FW];
   assign rsp_bus.cell_y     = pos_y_ff[drs_pkg::POS_W-1:FW];
   assign rsp_bus.step_neg_x = stx_ff;
   assign rsp_bus.step_neg_y = sty_ff;
   assign rsp_bus.delta_x    = delta_x_ff;
   assign rsp_bus.delta_y    = delta_y_ff;
   assign rsp_bus.side_x     = side_x_ff;
   assign rsp_bus.side_y     = side_y_ff;

   // ---------------- assertions ----------------
   `DRS_ASSERT_IMPL(a_col_corr, clock, reset, v2_ff, rem_c < QW_W'(2 * SCREEN_WIDTH), "column scaling needs more than one correction")
   `DRS_ASSERT_IMPL(a_axis_delta, clock, reset, vo_ff, (delta_x_ff == drs_pkg::DIST_ONE) || (delta_y_ff == drs_pkg::DIST_ONE), "no unit axis on response")
   `DRS_ASSERT_IMPL(a_step_sign, clock, reset, vo_ff, (stx_ff == rdx_ff[drs_pkg::DIR_W-1]) && (sty_ff == rdy_ff[drs_pkg::DIR_W-1]), "step sign disagrees with ray direction")
   `DRS_ASSERT_NEXT(a_div_hold, clock, reset, v6_ff && !div_in_ready, v6_ff && $stable(tag6_ff), "stalled ray lost before divider")

endmodule

// ----- tb/sv/tb_dda_ray_setup_unit.sv -----
// Self-checking testbench for the DDA ray setup unit: directed table, then random sweeps.
`timescale 1ns / 1ps

module tb_dda_ray_setup_unit;
   import drs_pkg::*;

   localparam int SCREEN_W = 1024;
   localparam int N_DIRECTED = 20;
   localparam int N_PHASES = 8;
   localparam int RAYS_PER_PHASE = 144;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [63:0] UNIT = 64'h1_0000;

   typedef struct packed {
      logic signed [DIR_W-1:0] ray_dir_x;
      logic signed [DIR_W-1:0] ray_dir_y;
      logic [CELL_W-1:0]       cell_x;
      logic [CELL_W-1:0]       cell_y;
      logic                    step_neg_x;
      logic                    step_neg_y;
      logic [DIST_W-1:0]       delta_x;
      logic [DIST_W-1:0]       delta_y;
      logic [DIST_W-1:0]       side_x;
      logic [DIST_W-1:0]       side_y;
   } ray_setup_t;

   typedef struct packed {
      orient_type           orient;
      logic [POS_W-1:0]     pos_x;
      logic [POS_W-1:0]     pos_y;
      logic [SCALE_W-1:0]   scale;
      logic [COLUMN_W-1:0]  column;
      logic                 typed;
      ray_setup_t           want;
   } directed_row_t;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   drs_req_if req_ch ();
   drs_rsp_if rsp_ch ();

   dda_ray_setup_unit #(.SCREEN_WIDTH(SCREEN_W)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Viewer registers as the block should hold them
   orient_type         cfg_orient = ORIENT_NORTH;
   logic [POS_W-1:0]   cfg_pos_x = POS_RESET;
   logic [POS_W-1:0]   cfg_pos_y = POS_RESET;
   logic [SCALE_W-1:0] cfg_scale = SCALE_RESET;

   ray_setup_t pending_rays[$];
   int mismatch_count = 0;
   bit req_idling = 1'b1;
   bit rsp_idling = 1'b1;
   int hold_request = 0;

   directed_row_t directed_rows [N_DIRECTED] = '{
      '{ORIENT_NORTH, POS_RESET, POS_RESET, SCALE_RESET, 12'd512, 1'b1,
        '{18'sd0, -18'sd65536, 8'd1, 8'd1, 1'b0, 1'b1, DIST_MAX, DIST_ONE,
          32'h7FFF_FFFF, 32'h0000_8000}},
      '{ORIENT_NORTH, POS_RESET, POS_RESET, SCALE_RESET, 12'd0,    1'b0, '0},
      '{ORIENT_NORTH, POS_RESET, POS_RESET, SCALE_RESET, 12'd1023, 1'b0, '0},
      '{ORIENT_NORTH, POS_RESET, POS_RESET, SCALE_RESET, 12'd1024, 1'b0, '0},
      '{ORIENT_NORTH, POS_RESET, POS_RESET, SCALE_RESET, 12'd4095, 1'b0, '0},
      '{ORIENT_NORTH, POS_RESET, POS_RESET, SCALE_RESET, 12'd511,  1'b0, '0},
      '{ORIENT_NORTH, POS_RESET, POS_RESET, SCALE_RESET, 12'd513,  1'b0, '0},
      // plane of one LSB: delta saturates
      '{ORIENT_NORTH, POS_RESET, POS_RESET, 16'd1, 12'd0, 1'b1,
        '{-18'sd1, -18'sd65536, 8'd1, 8'd1, 1'b1, 1'b1, DIST_MAX, DIST_ONE,
          32'h7FFF_FFFF, 32'h0000_8000}},
      '{ORIENT_NORTH, POS_RESET, POS_RESET, 16'd1, 12'd1023, 1'b0, '0},
      '{ORIENT_SOUTH, 24'd0, 24'd0, 16'hFFFF, 12'd0,    1'b0, '0},
      '{ORIENT_SOUTH, 24'd0, 24'd0, 16'hFFFF, 12'd1023, 1'b0, '0},
      '{ORIENT_SOUTH, 24'd0, 24'd0, 16'hFFFF, 12'd700,  1'b0, '0},
      // zero plane: y direction is zero, step +1, side from the full fraction
      '{ORIENT_EAST, 24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 12'd0, 1'b1,
        '{18'sd65536, 18'sd0, 8'd255, 8'd255, 1'b0, 1'b0, DIST_ONE, DIST_MAX,
          32'd1, 32'h0000_FFFF}},
      '{ORIENT_EAST, 24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 12'd300, 1'b0, '0},
      '{ORIENT_WEST, 24'd0, 24'h01_0000, SCALE_RESET, 12'd0,    1'b0, '0},
      '{ORIENT_WEST, 24'd0, 24'h01_0000, SCALE_RESET, 12'd1023, 1'b0, '0},
      '{ORIENT_WEST, 24'd0, 24'h01_0000, SCALE_RESET, 12'd2048, 1'b0, '0},
      '{ORIENT_NORTH, 24'h7F_8001, 24'h00_FFFF, 16'hFFFF, 12'd256,  1'b0, '0},
      '{ORIENT_NORTH, 24'h7F_8001, 24'h00_FFFF, 16'hFFFF, 12'hAAA,  1'b0, '0},
      '{ORIENT_NORTH, 24'h7F_8001, 24'h00_FFFF, 16'hFFFF, 12'h555,  1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL dda_ray_setup_unit");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("mismatch %s at %0t: got %0h want %0h", what, $realtime, got, want);
   endtask

   function automatic logic [DIST_W-1:0] recip_dist(input logic [63:0] mag);
      logic [63:0] q;
      if (mag == 0)
         return DIST_MAX;
      q = 64'h1_0000_0000 / mag;
      return (q > 64'hFFFF_FFFF) ? DIST_MAX : q[DIST_W-1:0];
   endfunction

   function automatic logic [DIST_W-1:0] first_line_dist(input logic [POS_W-1:0] pos,
                                                         input logic neg,
                                                         input logic [DIST_W-1:0] delta);
      logic [63:0] f;
      logic [63:0] s;
      f = neg ? 64'(pos[FRAC_W-1:0]) : UNIT - 64'(pos[FRAC_W-1:0]);
      s = (f * 64'(delta)) >> 16;
      return (s > 64'hFFFF_FFFF) ? DIST_MAX : s[DIST_W-1:0];
   endfunction

   function automatic ray_setup_t setup_ray(input logic [COLUMN_W-1:0] column);
      logic [63:0] col, scaled, cam_mag, pmag, xmag, ymag;
      logic cam_neg, xneg, yneg;
      ray_setup_t r;
      col = 64'(column);
      if (col > 64'(SCREEN_W - 1))
         col = 64'(SCREEN_W - 1);
      scaled = (2 * col * UNIT) / 64'(SCREEN_W);
      cam_neg = scaled < UNIT;
      cam_mag = cam_neg ? UNIT - scaled : scaled - UNIT;
      pmag = (64'(cfg_scale) * cam_mag) >> 16;
      case (cfg_orient)
         ORIENT_NORTH: begin
            xmag = pmag; xneg = cam_neg;  ymag = UNIT; yneg = 1'b1;
         end
         ORIENT_SOUTH: begin
            xmag = pmag; xneg = !cam_neg; ymag = UNIT; yneg = 1'b0;
         end
         ORIENT_EAST: begin
            xmag = UNIT; xneg = 1'b0; ymag = pmag; yneg = cam_neg;
         end
         default: begin
            xmag = UNIT; xneg = 1'b1; ymag = pmag; yneg = !cam_neg;
         end
      endcase
      // a zero component steps +1
      if (xmag == 0) xneg = 1'b0;
      if (ymag == 0) yneg = 1'b0;
      r.ray_dir_x = DIR_W'(xneg ? 64'd0 - xmag : xmag);
      r.ray_dir_y = DIR_W'(yneg ? 64'd0 - ymag : ymag);
      r.cell_x = cfg_pos_x[POS_W-1:FRAC_W];
      r.cell_y = cfg_pos_y[POS_W-1:FRAC_W];
      r.step_neg_x = xneg;
      r.step_neg_y = yneg;
      r.delta_x = recip_dist(xmag);
      r.delta_y = recip_dist(ymag);
      r.side_x = first_line_dist(cfg_pos_x, xneg, r.delta_x);
      r.side_y = first_line_dist(cfg_pos_y, yneg, r.delta_y);
      return r;
   endfunction

   task automatic compare_ray(input ray_setup_t got, input ray_setup_t want);
      if (got.ray_dir_x !== want.ray_dir_x)
         flag_mismatch("ray_dir_x", 64'($unsigned(got.ray_dir_x)),
                       64'($unsigned(want.ray_dir_x)));
      if (got.ray_dir_y !== want.ray_dir_y)
         flag_mismatch("ray_dir_y", 64'($unsigned(got.ray_dir_y)),
                       64'($unsigned(want.ray_dir_y)));
      if (got.cell_x !== want.cell_x) flag_mismatch("cell_x", got.cell_x, want.cell_x);
      if (got.cell_y !== want.cell_y) flag_mismatch("cell_y", got.cell_y, want.cell_y);
      if (got.step_neg_x !== want.step_neg_x)
         flag_mismatch("step_neg_x", got.step_neg_x, want.step_neg_x);
      if (got.step_neg_y !== want.step_neg_y)
         flag_mismatch("step_neg_y", got.step_neg_y, want.step_neg_y);
      if (got.delta_x !== want.delta_x) flag_mismatch("delta_x", got.delta_x, want.delta_x);
      if (got.delta_y !== want.delta_y) flag_mismatch("delta_y", got.delta_y, want.delta_y);
      if (got.side_x !== want.side_x) flag_mismatch("side_x", got.side_x, want.side_x);
      if (got.side_y !== want.side_y) flag_mismatch("side_y", got.side_y, want.side_y);
   endtask

   // Result side: check every accepted transaction against the oldest expectation
   always @(posedge clock) begin : take_ray
      ray_setup_t got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.ray_dir_x = rsp_ch.ray_dir_x;
         got.ray_dir_y = rsp_ch.ray_dir_y;
         got.cell_x = rsp_ch.cell_x;
         got.cell_y = rsp_ch.cell_y;
         got.step_neg_x = rsp_ch.step_neg_x;
         got.step_neg_y = rsp_ch.step_neg_y;
         got.delta_x = rsp_ch.delta_x;
         got.delta_y = rsp_ch.delta_y;
         got.side_x = rsp_ch.side_x;
         got.side_y = rsp_ch.side_y;
         if (pending_rays.size() == 0)
            flag_mismatch("unexpected result", 64'(got.delta_x), 64'd0);
         else
            compare_ray(got, pending_rays.pop_front());
      end
   end

   // Result side ready: random back-pressure, plus a counted hold-off on request
   initial begin : drive_ready
      int n;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= !(rsp_idling && $urandom_range(99) < 16);
      end
   end

   // Leaves valid high after acceptance; the next call or a drain decides its fate
   task automatic offer_column(input logic [COLUMN_W-1:0] column, input ray_setup_t want);
      while (req_idling && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.column <= column;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_rays.push_back(want);
   endtask

   task automatic wait_for_rays_out();
      req_ch.valid <= 1'b0;
      while (pending_rays.size() != 0) @(posedge clock);
   endtask

   // One APB transfer; psel stays high so transfers can run back to back
   task automatic apb_access(input bit is_write, input logic [1:0] index,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= {index, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
   endtask

   task automatic csr_check(input logic [1:0] index, input logic [31:0] want);
      logic [31:0] got;
      apb_access(1'b0, index, 32'h0, got);
      if (got !== want) flag_mismatch("register readback", got, want);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] wdata;
      logic [31:0] unused;
      case (index)
         REG_ORIENTATION: mask = 32'h0000_0003;
         REG_PLANE_SCALE: mask = 32'h0000_FFFF;
         default:         mask = 32'h00FF_FFFF;
      endcase
      // junk above the register width must be dropped
      wdata = ($urandom & ~mask) | (value & mask);
      apb_access(1'b1, index, wdata, unused);
      case (index)
         REG_ORIENTATION: cfg_orient = orient_type'(value[1:0]);
         REG_POS_X:       cfg_pos_x = value[POS_W-1:0];
         REG_POS_Y:       cfg_pos_y = value[POS_W-1:0];
         default:         cfg_scale = value[SCALE_W-1:0];
      endcase
      csr_check(index, value & mask);
   endtask

   task automatic set_view(input orient_type orient, input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py, input logic [SCALE_W-1:0] scale);
      wait_for_rays_out();
      csr_write(REG_ORIENTATION, 32'(orient));
      csr_write(REG_POS_X, 32'(px));
      csr_write(REG_POS_Y, 32'(py));
      csr_write(REG_PLANE_SCALE, 32'(scale));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin : stimulus
      int p;
      int i;
      directed_row_t row;
      logic [COLUMN_W-1:0] col;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic [SCALE_W-1:0] scale;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.column <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(REG_ORIENTATION, 32'(ORIENT_NORTH));
      csr_check(REG_POS_X, 32'(POS_RESET));
      csr_check(REG_POS_Y, 32'(POS_RESET));
      csr_check(REG_PLANE_SCALE, 32'(SCALE_RESET));
      psel <= 1'b0;
      penable <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.orient != cfg_orient || row.pos_x != cfg_pos_x || row.pos_y != cfg_pos_y
             || row.scale != cfg_scale)
            set_view(row.orient, row.pos_x, row.pos_y, row.scale);
         offer_column(row.column, row.typed ? row.want : setup_ray(row.column));
      end

      col = '0;
      for (p = 0; p < N_PHASES; p++) begin
         px = $urandom_range(0, 24'hFF_FFFF);
         py = $urandom_range(0, 24'hFF_FFFF);
         if ($urandom_range(3) == 0) px[FRAC_W-1:0] = '0;
         if ($urandom_range(3) == 0) py[FRAC_W-1:0] = '0;
         scale = ($urandom_range(3) == 0) ? SCALE_W'($urandom_range(0, 3)) :
                                            SCALE_W'($urandom);
         case (p)
            0: set_view(orient_type'(p % 4), 24'd0, 24'hFF_FFFF, 16'hFFFF);
            1: set_view(orient_type'(p % 4), 24'hFF_FFFF, 24'd0, 16'd0);
            default: set_view(orient_type'(p % 4), px, py, scale);
         endcase
         // phase 2 runs flat out on both sides
         req_idling = (p != 2);
         rsp_idling = (p != 2);
         if (p == 3)
            hold_request = 400;
         for (i = 0; i < RAYS_PER_PHASE; i++) begin
            if (p == 5 && i == RAYS_PER_PHASE / 2)
               wait_for_rays_out();
            // half the time a column sweep as the sequencer would feed it, else random jumps
            if ($urandom_range(1) == 1)
               col = (col >= COLUMN_W'(SCREEN_W - 1)) ? '0 : col + 1'b1;
            else if ($urandom_range(7) == 0)
               col = $urandom_range(SCREEN_W, 4095);
            else
               col = $urandom_range(0, SCREEN_W - 1);
            offer_column(col, setup_ray(col));
         end
      end

      wait_for_rays_out();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS dda_ray_setup_unit");
      else
         $display("FAIL dda_ray_setup_unit");
      $finish;
   end

endmodule
